[hdl/gxp_pkg.sv]
// gxp_pkg: shared types, sizes and helpers for the glyph row pixel expander.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gxp_pkg;

   // glyph geometry
   localparam int GLYPH_SIZE = 16;
   localparam int MAX_ROW_W  = 24;
   localparam int SRC_ROW_W  = (GLYPH_SIZE > 1) ? $clog2(GLYPH_SIZE) : 1;
   localparam int BITS_W     = 16;
   localparam int PIX_W      = 5;
   localparam int ALPHA_W    = 8;

   // output row widths, clipped
   localparam int SMALL_W_RAW = GLYPH_SIZE;
   localparam int LARGE_W_RAW = GLYPH_SIZE * 3 / 2;
   localparam int SMALL_W     = (SMALL_W_RAW > MAX_ROW_W) ? MAX_ROW_W : SMALL_W_RAW;
   localparam int LARGE_W     = (LARGE_W_RAW > MAX_ROW_W) ? MAX_ROW_W : LARGE_W_RAW;
   localparam logic [PIX_W-1:0] SMALL_LAST_X = PIX_W'(SMALL_W - 1);
   localparam logic [PIX_W-1:0] LARGE_LAST_X = PIX_W'(LARGE_W - 1);
   localparam logic [SRC_ROW_W-1:0] FINAL_SRC_ROW = SRC_ROW_W'(GLYPH_SIZE - 1);

   localparam logic [ALPHA_W-1:0] ALPHA_ON  = 8'hff;
   localparam logic [ALPHA_W-1:0] ALPHA_OFF = 8'h00;

   // 2/3 by reciprocal: floor(v * 171 / 512) is exact for v below 48
   localparam logic [8:0] RECIP_THIRD = 9'd171;

   // queue between front and back
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // one classified row, as the back end needs it
   typedef struct packed {
      logic [BITS_W-1:0] row_bits;
      logic [PIX_W-1:0]  y0;
      logic              two_rows;
      logic              wide_mode;
      logic              final_row;
   } row_job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic not_empty;
      logic full;
   } q_status_type;

endpackage

`default_nettype wire

[hdl/gxp_front.sv]
// gxp_front: accepts source rows, tracks the glyph row counter and mode,
// and turns each row into a job for the queue. Depends on gxp_pkg.
`default_nettype none

module gxp_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [gxp_pkg::BITS_W-1:0]       req_row_bits,
   input  wire logic                             req_start_of_glyph,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_large_mode,
   input  wire gxp_pkg::q_status_type            q_status,
   output logic                                  push,
   output gxp_pkg::row_job_type                  push_job
);

   logic                              large_mode_ff;
   logic [gxp_pkg::SRC_ROW_W-1:0]     source_row_ff;
   logic [gxp_pkg::SRC_ROW_W-1:0]     source_row_in;
   logic [gxp_pkg::SRC_ROW_W-1:0]     s;
   logic [gxp_pkg::SRC_ROW_W+1:0]     y_full;
   logic [gxp_pkg::SRC_ROW_W+1:0]     y_half;
   logic                              final_row;
   logic                              accept;

   // stall only on a full queue
   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign push      = accept;

   // classify the row
   always_comb begin
      s         = req_start_of_glyph ? '0 : source_row_ff;
      final_row = (s >= gxp_pkg::FINAL_SRC_ROW);
      y_full    = (gxp_pkg::SRC_ROW_W+2)'(s) + (gxp_pkg::SRC_ROW_W+2)'(s)
                + (gxp_pkg::SRC_ROW_W+2)'(s) + (gxp_pkg::SRC_ROW_W+2)'(1);
      y_half    = y_full >> 1;
      push_job.row_bits  = req_row_bits;
      push_job.wide_mode = large_mode_ff;
      push_job.final_row = final_row;
      push_job.two_rows  = large_mode_ff && !s[0];
      push_job.y0        = large_mode_ff ? gxp_pkg::PIX_W'(y_half) : gxp_pkg::PIX_W'(s);
      source_row_in      = final_row ? '0 : s + gxp_pkg::SRC_ROW_W'(1);
   end

   // mode register and row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         large_mode_ff <= 1'b0;
         source_row_ff <= '0;
      end else begin
         if (csr_valid) large_mode_ff <= csr_large_mode;
         if (accept)    source_row_ff <= source_row_in;
      end
   end

endmodule

`default_nettype wire

[hdl/gxp_queue.sv]
// gxp_queue: short job queue that decouples the front and back ends.
// Depends on gxp_pkg.
`default_nettype none

module gxp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire gxp_pkg::row_job_type   push_job,
   input  wire logic                   pop,
   output gxp_pkg::row_job_type        head_job,
   output gxp_pkg::q_status_type       q_status
);

   gxp_pkg::row_job_type              mem_ff [gxp_pkg::QDEPTH];
   logic [gxp_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [gxp_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [gxp_pkg::QCNT_W-1:0]        count_ff;
   logic [gxp_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [gxp_pkg::QPTR_W-1:0]        rd_ptr_in;

   localparam logic [gxp_pkg::QPTR_W-1:0] LAST_PTR = gxp_pkg::QPTR_W'(gxp_pkg::QDEPTH - 1);
   localparam logic [gxp_pkg::QCNT_W-1:0] FULL_CNT = gxp_pkg::QCNT_W'(gxp_pkg::QDEPTH);

   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == FULL_CNT);
   assign head_job           = mem_ff[rd_ptr_ff];

   // pointer wrap
   always_comb begin
      wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + gxp_pkg::QPTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + gxp_pkg::QPTR_W'(1);
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
         priority if (push && !pop) begin
            count_ff <= count_ff + gxp_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - gxp_pkg::QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[hdl/gxp_back.sv]
// gxp_back: walks the head job pixel by pixel and drives the result register.
// Depends on gxp_pkg.
`default_nettype none

module gxp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gxp_pkg::row_job_type          head_job,
   input  wire gxp_pkg::q_status_type         q_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gxp_pkg::PIX_W-1:0]          rsp_pixel_x,
   output logic [gxp_pkg::PIX_W-1:0]          rsp_pixel_y,
   output logic [gxp_pkg::ALPHA_W-1:0]        rsp_alpha,
   output logic                               rsp_last_of_item,
   output logic                               rsp_glyph_done
);

   logic [gxp_pkg::PIX_W-1:0]    x_ff;
   logic                         r_ff;
   logic                         rsp_valid_ff;
   logic [gxp_pkg::PIX_W-1:0]    pixel_x_ff;
   logic [gxp_pkg::PIX_W-1:0]    pixel_y_ff;
   logic [gxp_pkg::ALPHA_W-1:0]  alpha_ff;
   logic                         last_ff;
   logic                         done_ff;

   logic                         advance;
   logic                         emit;
   logic                         end_of_row;
   logic                         last_pix;
   logic [gxp_pkg::PIX_W-1:0]    last_x;
   logic [14:0]                  scaled;
   logic [5:0]                   sx;
   logic                         bit_set;
   logic [gxp_pkg::ALPHA_W-1:0]  alpha_in;
   logic [gxp_pkg::PIX_W-1:0]    y_in;

   // output register frees up when empty or taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && q_status.not_empty;

   // pixel sampling and row/column end
   always_comb begin
      last_x     = head_job.wide_mode ? gxp_pkg::LARGE_LAST_X : gxp_pkg::SMALL_LAST_X;
      end_of_row = (x_ff == last_x);
      last_pix   = end_of_row && (r_ff || !head_job.two_rows);
      scaled     = {9'd0, x_ff, 1'b0} * {6'd0, gxp_pkg::RECIP_THIRD};
      sx         = head_job.wide_mode ? scaled[14:9] : {1'b0, x_ff};
      bit_set    = (sx < 6'd16) && head_job.row_bits[~sx[3:0]];
      alpha_in   = bit_set ? gxp_pkg::ALPHA_ON : gxp_pkg::ALPHA_OFF;
      y_in       = head_job.y0 + gxp_pkg::PIX_W'(r_ff);
   end

   assign pop = emit && last_pix;

   // column and row walk
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         r_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) rsp_valid_ff <= q_status.not_empty;
         if (emit) begin
            if (last_pix) begin
               x_ff <= '0;
               r_ff <= 1'b0;
            end else if (end_of_row) begin
               x_ff <= '0;
               r_ff <= 1'b1;
            end else begin
               x_ff <= x_ff + gxp_pkg::PIX_W'(1);
            end
         end
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (emit) begin
         pixel_x_ff <= x_ff;
         pixel_y_ff <= y_in;
         alpha_ff   <= alpha_in;
         last_ff    <= last_pix;
         done_ff    <= last_pix && head_job.final_row;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = pixel_x_ff;
   assign rsp_pixel_y      = pixel_y_ff;
   assign rsp_alpha        = alpha_ff;
   assign rsp_last_of_item = last_ff;
   assign rsp_glyph_done   = done_ff;

endmodule

`default_nettype wire

[hdl/glyph_row_pixel_expander_unit.sv]
// glyph_row_pixel_expander_unit: top level of the glyph row pixel expander.
// Depends on gxp_pkg, gxp_front, gxp_queue and gxp_back.
//
// Usage:
//   req_*  takes one 16-pixel 1-bpp glyph row per word (bit 15 leftmost) with a
//          start-of-glyph flag that restarts the row count.
//   rsp_*  gives one 8-bit alpha pixel per word with its x, y, a last-of-row-item
//          flag and a glyph-done flag on the final pixel of the glyph.
//   csr_*  writes large_mode (0: 16x16 output, 1: 24x24 scaled by 3/2); always
//          ready, write only while the block is idle.
// Path: a taken row word is written into the job queue; its first pixel then
//   moves into the result register once the word is at the queue head and the
//   result register is free.
// Throughput: one pixel per cycle from the back-end walker while rsp_stall is
//   low: a row word gives 16 pixels in small mode, 24 (odd source row) or 48
//   (even source row) in large mode. A two-entry job queue lets the next row word
//   be taken while the current one is still being expanded.
// Reset clears the mode, the row counter, the queue and the result valid.
// While rsp_stall is high with rsp_valid set, the result word holds, the walker
//   pauses, and once the queue fills req_stall rises.
`default_nettype none

module glyph_row_pixel_expander_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gxp_pkg::BITS_W-1:0]    req_row_bits,
   input  wire logic                          req_start_of_glyph,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [gxp_pkg::PIX_W-1:0]          rsp_pixel_x,
   output logic [gxp_pkg::PIX_W-1:0]          rsp_pixel_y,
   output logic [gxp_pkg::ALPHA_W-1:0]        rsp_alpha,
   output logic                               rsp_last_of_item,
   output logic                               rsp_glyph_done,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_large_mode
);

   gxp_pkg::q_status_type  q_status;
   gxp_pkg::row_job_type   push_job;
   gxp_pkg::row_job_type   head_job;
   logic                   push;
   logic                   pop;
   logic                   csr_write;

   // register writes always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   gxp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_row_bits       (req_row_bits),
      .req_start_of_glyph (req_start_of_glyph),
      .csr_valid          (csr_write),
      .csr_large_mode     (csr_large_mode),
      .q_status           (q_status),
      .push               (push),
      .push_job           (push_job)
   );

   gxp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   gxp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_job         (head_job),
      .q_status         (q_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_alpha        (rsp_alpha),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_glyph_done   (rsp_glyph_done)
   );

endmodule

`default_nettype wire

[hdl/gxp_checker.sv]
// gxp_checker: port-level assertions for glyph_row_pixel_expander_unit, bound
// to the top level. Depends on gxp_pkg.
`default_nettype none

module gxp_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [gxp_pkg::PIX_W-1:0]     rsp_pixel_x,
   input  wire logic [gxp_pkg::PIX_W-1:0]     rsp_pixel_y,
   input  wire logic [gxp_pkg::ALPHA_W-1:0]   rsp_alpha,
   input  wire logic                          rsp_last_of_item,
   input  wire logic                          rsp_glyph_done
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) &&
         $stable(rsp_pixel_y) && $stable(rsp_alpha) && $stable(rsp_last_of_item))
      else $error("stalled result word changed");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // glyph end only on the last pixel of a row word
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_glyph_done |-> rsp_last_of_item)
      else $error("glyph done without last of item");

   // alpha is binary
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha == gxp_pkg::ALPHA_ON) || (rsp_alpha == gxp_pkg::ALPHA_OFF))
      else $error("alpha not on or off");

   // a row word ends on its last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_item |->
         (rsp_pixel_x == gxp_pkg::SMALL_LAST_X) || (rsp_pixel_x == gxp_pkg::LARGE_LAST_X))
      else $error("last of item off the row end");

endmodule

bind glyph_row_pixel_expander_unit gxp_checker u_gxp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel_x      (rsp_pixel_x),
   .rsp_pixel_y      (rsp_pixel_y),
   .rsp_alpha        (rsp_alpha),
   .rsp_last_of_item (rsp_last_of_item),
   .rsp_glyph_done   (rsp_glyph_done)
);

`default_nettype wire

[tb/tb_glyph_row_pixel_expander_unit.sv]
// tb_glyph_row_pixel_expander_unit: self-checking bench for the glyph row pixel expander.
// Predicts every alpha pixel from the row words and the mode, and checks rsp word by word.
// Depends on gxp_pkg and glyph_row_pixel_expander_unit.
`default_nettype none

module tb_glyph_row_pixel_expander_unit;

   // cycles allowed after the last pixel before the block counts as idle
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [gxp_pkg::PIX_W-1:0]   x;
      logic [gxp_pkg::PIX_W-1:0]   y;
      logic [gxp_pkg::ALPHA_W-1:0] alpha;
      logic                        last;
      logic                        done;
   } pixel_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [gxp_pkg::BITS_W-1:0]  req_row_bits = '0;
   logic                        req_start_of_glyph = 1'b0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [gxp_pkg::PIX_W-1:0]   rsp_pixel_x;
   logic [gxp_pkg::PIX_W-1:0]   rsp_pixel_y;
   logic [gxp_pkg::ALPHA_W-1:0] rsp_alpha;
   logic                        rsp_last_of_item;
   logic                        rsp_glyph_done;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_large_mode = 1'b0;

   // predictor state
   pixel_type pixel_q[$];
   int        row_index = 0;
   logic      mode_large = 1'b0;

   int errors = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   pixel_type want;

   glyph_row_pixel_expander_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_row_bits       (req_row_bits),
      .req_start_of_glyph (req_start_of_glyph),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_alpha          (rsp_alpha),
      .rsp_last_of_item   (rsp_last_of_item),
      .rsp_glyph_done     (rsp_glyph_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_large_mode     (csr_large_mode)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far above the slowest legal run
   initial begin
      #4000000;
      $display("[glyph_row_pixel_expander_unit] ERROR");
      $finish;
   end

   task automatic flag_error(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int got, input int exp_val);
      if (got != exp_val)
         flag_error($sformatf("%s got %0d want %0d", name, got, exp_val));
   endtask

   // expand one source row into the pixels it must produce
   task automatic expand_row(input logic [gxp_pkg::BITS_W-1:0] bits, input logic sog);
      int s, y0, rows, width, total, n, sx;
      logic final_row;
      pixel_type p;
      if (sog)
         row_index = 0;
      s = row_index;
      final_row = (s >= gxp_pkg::GLYPH_SIZE - 1);
      if (mode_large) begin
         y0 = (3 * s + 1) / 2;
         rows = (s % 2 == 0) ? 2 : 1;
         width = gxp_pkg::GLYPH_SIZE * 3 / 2;
      end else begin
         y0 = s;
         rows = 1;
         width = gxp_pkg::GLYPH_SIZE;
      end
      if (width > gxp_pkg::MAX_ROW_W)
         width = gxp_pkg::MAX_ROW_W;
      total = rows * width;
      n = 0;
      for (int r = 0; r < rows; r++) begin
         for (int x = 0; x < width; x++) begin
            sx = mode_large ? (x * 2 / 3) : x;
            p.x = gxp_pkg::PIX_W'(x);
            p.y = gxp_pkg::PIX_W'(y0 + r);
            p.alpha = (sx < gxp_pkg::BITS_W && bits[gxp_pkg::BITS_W-1-sx]) ?
                      gxp_pkg::ALPHA_ON : gxp_pkg::ALPHA_OFF;
            p.last = (n + 1 == total);
            p.done = p.last && final_row;
            pixel_q.push_back(p);
            n++;
         end
      end
      row_index = final_row ? 0 : s + 1;
   endtask

   // offer one row word; returns at the edge that takes it
   task automatic send_row(input logic [gxp_pkg::BITS_W-1:0] bits, input logic sog);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_row_bits <= gxp_pkg::BITS_W'($urandom);
         req_start_of_glyph <= 1'($urandom_range(1));
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_row_bits <= bits;
      req_start_of_glyph <= sog;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expand_row(bits, sog);
   endtask

   // stop offering and wait until every pixel has come out
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic use_large);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_large_mode <= use_large;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      mode_large = use_large;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [gxp_pkg::BITS_W-1:0] pick_bits;
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return gxp_pkg::BITS_W'(1) << $urandom_range(gxp_pkg::BITS_W - 1);
         default: return gxp_pkg::BITS_W'($urandom);
      endcase
   endfunction

   // small mode: edge patterns and a restart in the middle of a glyph
   task automatic test_small_rows;
      write_mode(1'b0);
      send_row(16'hffff, 1'b1);
      send_row(16'h0000, 1'b0);
      send_row(16'h8000, 1'b0);
      send_row(16'h0001, 1'b0);
      send_row(16'haaaa, 1'b1);
      drain();
   endtask

   // large mode: one whole glyph, then a row that wraps without the start flag
   task automatic test_large_glyph;
      logic [gxp_pkg::BITS_W-1:0] pats[4] = '{16'hffff, 16'h0000, 16'h8001, 16'h5555};
      write_mode(1'b1);
      for (int k = 0; k < gxp_pkg::GLYPH_SIZE; k++)
         send_row(pats[k % 4], k == 0);
      send_row(16'hc003, 1'b0);
      drain();
   endtask

   // mode flips between rows of one glyph
   task automatic test_mode_change_in_glyph;
      write_mode(1'b1);
      send_row(16'hf0f0, 1'b1);
      write_mode(1'b0);
      send_row(16'h0f0f, 1'b0);
      write_mode(1'b1);
      send_row(16'h9249, 1'b0);
      drain();
   endtask

   // mostly whole glyphs with random rows, some partial glyphs and loose rows
   task automatic send_random_rows(input int count);
      int sent, len;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) < 8) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, gxp_pkg::GLYPH_SIZE - 1)
                                           : gxp_pkg::GLYPH_SIZE;
            for (int k = 0; k < len && sent < count; k++) begin
               send_row(pick_bits(), (k == 0) ? ($urandom_range(4) != 0) : 1'b0);
               sent++;
            end
         end else begin
            send_row(pick_bits(), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   task automatic test_random_phase(input int idle, input int stall, input logic first_large);
      send_idle_pct = idle;
      stall_pct = stall;
      write_mode(first_large);
      send_random_rows(50);
      write_mode(!first_large);
      send_random_rows(50);
      drain();
   endtask

   // long receiver hold-off while rows keep coming, so req_stall must rise
   task automatic test_backpressure;
      send_idle_pct = 0;
      stall_pct = 0;
      write_mode(1'b1);
      hold_left = HOLD_CYCLES;
      send_random_rows(45);
      drain();
   endtask

   // receiver: random stall, or a held stretch when asked
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare each taken pixel word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            flag_error($sformatf("unexpected pixel x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y));
         end else begin
            want = pixel_q.pop_front();
            check_field("pixel_x", rsp_pixel_x, want.x);
            check_field("pixel_y", rsp_pixel_y, want.y);
            check_field("alpha", rsp_alpha, want.alpha);
            check_field("last_of_item", rsp_last_of_item, want.last);
            check_field("glyph_done", rsp_glyph_done, want.done);
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_rows();
      test_large_glyph();
      test_mode_change_in_glyph();
      test_random_phase(0, 0, 1'b0);
      test_random_phase(56, 0, 1'b1);
      test_random_phase(0, 56, 1'b0);
      test_random_phase(33, 33, 1'b1);
      test_backpressure();
      drain();
      if (pixel_q.size() != 0)
         flag_error($sformatf("%0d pixels never arrived", pixel_q.size()));
      if (errors == 0) begin
         $display("[glyph_row_pixel_expander_unit] OK");
      end else begin
         $display("[glyph_row_pixel_expander_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
